### rtl/core/mcs_pkg.sv
// Shared types, constants and the sine table generator for the metronome click synthesiser.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
`default_nettype none
package mcs_pkg;

   localparam int BEATS_PER_BAR_DEF    = 4;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_SAMPLES_PER_BEAT    = 3'd0;
   localparam logic [2:0] REG_CLICK_LENGTH        = 3'd1;
   localparam logic [2:0] REG_TONE_PHASE_STEP     = 3'd2;
   localparam logic [2:0] REG_ENVELOPE_PHASE_STEP = 3'd3;
   localparam logic [2:0] REG_BAR_COUNT           = 3'd4;

   localparam logic [19:0] SAMPLES_PER_BEAT_RST    = 20'd24000;
   localparam logic [15:0] CLICK_LENGTH_RST        = 16'd4800;
   localparam logic [31:0] TONE_PHASE_STEP_RST     = 32'd4294967;
   localparam logic [31:0] ENVELOPE_PHASE_STEP_RST = 32'd447392;
   localparam logic [11:0] BAR_COUNT_RST           = 12'd1;

   localparam longint Q30_ONE = 64'sd1073741824;

   // Per-sample flags that travel down the pipeline with the request.
   typedef struct packed {
      logic in_click;
      logic beat_start;
      logic track_last;
   } flags_type;

   typedef struct packed {
      logic [19:0] samples_per_beat;
      logic [15:0] click_length;
      logic [31:0] tone_phase_step;
      logic [31:0] envelope_phase_step;
      logic [11:0] bar_count;
   } cfg_type;

   function automatic longint qmul(longint a, longint b);
      return (a * b) / Q30_ONE;
   endfunction

   // Q1.15 sine of an angle in 2^-32 turns; evaluated at elaboration only.
   function automatic logic signed [16:0] sine_of_turn(logic [31:0] a);
      logic [1:0] quad;
      longint     t;
      longint     t2;
      longint     p;
      longint     mag;
      quad = a[31:30];
      t    = longint'({34'd0, a[29:0]});
      if (quad[0]) begin
         t = Q30_ONE - t;
      end
      t2 = qmul(t, t);
      p  = 64'sd172272;
      p  = qmul(p, t2) - 64'sd5026993;
      p  = qmul(p, t2) + 64'sd85569304;
      p  = qmul(p, t2) - 64'sd693598669;
      p  = qmul(p, t2) + 64'sd1686629713;
      p  = qmul(p, t);
      if (p < 0) begin
         p = 0;
      end
      if (p > Q30_ONE) begin
         p = Q30_ONE;
      end
      mag = (p + 64'sd16384) >>> 15;
      if (quad[1]) begin
         mag = -mag;
      end
      return 17'(mag);
   endfunction

endpackage
`default_nettype wire

### rtl/core/mcs_csr.sv
// Configuration registers of the metronome click synthesiser behind an APB-style port.
// Depends on mcs_pkg for register indexes, reset values and the configuration struct.
`default_nettype none
module mcs_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [4:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic      [31:0]     csr_prdata,
   output mcs_pkg::cfg_type     cfg
);

   mcs_pkg::cfg_type cfg_ff;
   mcs_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            mcs_pkg::REG_SAMPLES_PER_BEAT:    cfg_in.samples_per_beat    = csr_pwdata[19:0];
            mcs_pkg::REG_CLICK_LENGTH:        cfg_in.click_length        = csr_pwdata[15:0];
            mcs_pkg::REG_TONE_PHASE_STEP:     cfg_in.tone_phase_step     = csr_pwdata;
            mcs_pkg::REG_ENVELOPE_PHASE_STEP: cfg_in.envelope_phase_step = csr_pwdata;
            mcs_pkg::REG_BAR_COUNT:           cfg_in.bar_count           = csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.samples_per_beat    <= mcs_pkg::SAMPLES_PER_BEAT_RST;
         cfg_ff.click_length        <= mcs_pkg::CLICK_LENGTH_RST;
         cfg_ff.tone_phase_step     <= mcs_pkg::TONE_PHASE_STEP_RST;
         cfg_ff.envelope_phase_step <= mcs_pkg::ENVELOPE_PHASE_STEP_RST;
         cfg_ff.bar_count           <= mcs_pkg::BAR_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         mcs_pkg::REG_SAMPLES_PER_BEAT:    csr_prdata = {12'd0, cfg_ff.samples_per_beat};
         mcs_pkg::REG_CLICK_LENGTH:        csr_prdata = {16'd0, cfg_ff.click_length};
         mcs_pkg::REG_TONE_PHASE_STEP:     csr_prdata = cfg_ff.tone_phase_step;
         mcs_pkg::REG_ENVELOPE_PHASE_STEP: csr_prdata = cfg_ff.envelope_phase_step;
         mcs_pkg::REG_BAR_COUNT:           csr_prdata = {20'd0, cfg_ff.bar_count};
         default:                          csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### rtl/core/mcs_sequencer.sv
// Beat, bar and phase counters; turns each request into two table addresses and flags.
// Depends on mcs_pkg for the configuration and flag structs.
`default_nettype none
module mcs_sequencer #(
   parameter int BEATS_PER_BAR    = mcs_pkg::BEATS_PER_BAR_DEF,
   parameter int SINE_TABLE_DEPTH = mcs_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int AW               = $clog2(SINE_TABLE_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mcs_pkg::cfg_type  cfg,
   input  wire logic              accept,
   input  wire logic              restart,
   input  wire logic              load,
   output logic [AW-1:0]          tone_addr,
   output logic [AW-1:0]          env_addr,
   output mcs_pkg::flags_type     flags
);

   localparam int PW = 32 + AW + 1;

   logic [19:0] sib_ff,  sib_in;
   logic [13:0] beat_ff, beat_in;
   logic [31:0] tone_ff, tone_in;
   logic [31:0] env_ff,  env_in;

   logic [AW-1:0]      tone_addr_ff;
   logic [AW-1:0]      env_addr_ff;
   mcs_pkg::flags_type flags_ff;
   mcs_pkg::flags_type flags_in;

   logic [19:0] spb;
   logic [11:0] bars;
   logic [16:0] total;
   logic [13:0] last_beat;
   logic [19:0] sib_cur;
   logic [13:0] beat_cur;
   logic [31:0] tone_cur;
   logic [31:0] env_cur;
   logic [31:0] cos_phase;
   logic [PW-1:0] tone_prod;
   logic [PW-1:0] env_prod;
   logic        beat_end;
   logic        beat_last;

   always_comb begin
      spb       = (cfg.samples_per_beat == 20'd0) ? 20'd1 : cfg.samples_per_beat;
      bars      = (cfg.bar_count == 12'd0) ? 12'd1 : cfg.bar_count;
      total     = 17'({5'd0, bars} * 17'(BEATS_PER_BAR));
      last_beat = (total > 17'd16384) ? 14'd16383 : 14'(total - 17'd1);

      sib_cur   = restart ? 20'd0 : sib_ff;
      beat_cur  = restart ? 14'd0 : beat_ff;
      tone_cur  = restart ? 32'd0 : tone_ff;
      env_cur   = restart ? 32'd0 : env_ff;

      beat_end  = sib_cur >= (spb - 20'd1);
      beat_last = beat_cur >= last_beat;

      flags_in.in_click   = sib_cur < {4'd0, cfg.click_length};
      flags_in.beat_start = sib_cur == 20'd0;
      flags_in.track_last = beat_end & beat_last;

      // Entry index is (phase * depth) >> 32; the cosine is read a quarter turn ahead.
      cos_phase = env_cur + 32'h4000_0000;
      tone_prod = PW'(tone_cur) * PW'(SINE_TABLE_DEPTH);
      env_prod  = PW'(cos_phase) * PW'(SINE_TABLE_DEPTH);

      if (beat_end) begin
         sib_in  = 20'd0;
         tone_in = 32'd0;
         env_in  = 32'd0;
         beat_in = beat_last ? 14'd0 : beat_cur + 14'd1;
      end else begin
         sib_in  = sib_cur + 20'd1;
         tone_in = tone_cur + cfg.tone_phase_step;
         env_in  = env_cur + cfg.envelope_phase_step;
         beat_in = beat_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sib_ff  <= 20'd0;
         beat_ff <= 14'd0;
         tone_ff <= 32'd0;
         env_ff  <= 32'd0;
      end else if (accept) begin
         sib_ff  <= sib_in;
         beat_ff <= beat_in;
         tone_ff <= tone_in;
         env_ff  <= env_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tone_addr_ff <= tone_prod[32 +: AW];
         env_addr_ff  <= env_prod[32 +: AW];
         flags_ff     <= flags_in;
      end
   end

   assign tone_addr = tone_addr_ff;
   assign env_addr  = env_addr_ff;
   assign flags     = flags_ff;

endmodule
`default_nettype wire

### rtl/core/mcs_sine_rom.sv
// Two-port sine table with registered read data, built at elaboration.
// Depends on mcs_pkg for the sine generator and the flag struct.
`default_nettype none
module mcs_sine_rom #(
   parameter int SINE_TABLE_DEPTH = mcs_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int AW               = $clog2(SINE_TABLE_DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                load,
   input  wire logic [AW-1:0]       tone_addr,
   input  wire logic [AW-1:0]       env_addr,
   input  wire mcs_pkg::flags_type  flags_i,
   output logic signed [16:0]       sine_val,
   output logic signed [16:0]       cosine_val,
   output mcs_pkg::flags_type       flags_o
);

   logic signed [16:0] rom_w [SINE_TABLE_DEPTH];

   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
      localparam logic [31:0] ANGLE =
         32'((64'(k) << 32) / SINE_TABLE_DEPTH);
      localparam logic signed [16:0] ENTRY = mcs_pkg::sine_of_turn(ANGLE);
      assign rom_w[k] = ENTRY;
   end

   logic signed [16:0] sine_ff;
   logic signed [16:0] cosine_ff;
   mcs_pkg::flags_type flags_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         sine_ff   <= rom_w[tone_addr];
         cosine_ff <= rom_w[env_addr];
         flags_ff  <= flags_i;
      end
   end

   assign sine_val   = sine_ff;
   assign cosine_val = cosine_ff;
   assign flags_o    = flags_ff;

endmodule
`default_nettype wire

### rtl/core/mcs_mixer.sv
// Hann envelope times sine, clamp, and scaling to a 16-bit sample over two stages.
// Depends on mcs_pkg for the flag struct.
`default_nettype none
module mcs_mixer (
   input  wire logic                clock,
   input  wire logic                load_prod,
   input  wire logic                load_out,
   input  wire logic signed [16:0]  sine_val,
   input  wire logic signed [16:0]  cosine_val,
   input  wire mcs_pkg::flags_type  flags_i,
   output logic signed [15:0]       sample_value,
   output logic                     beat_start,
   output logic                     track_last
);

   logic signed [31:0] prod_ff, prod_in;
   mcs_pkg::flags_type flags_ff;
   logic signed [15:0] sample_ff, sample_in;
   logic               beat_start_ff;
   logic               track_last_ff;

   logic signed [17:0] env_diff;
   logic signed [17:0] env_val;
   logic signed [34:0] raw;
   logic signed [47:0] scaled;
   logic signed [47:0] biased;

   // Envelope (32768 - cos) / 2 lies in 0..32768, so the product stays within +-2^30.
   always_comb begin
      env_diff = 18'sd32768 - 18'(cosine_val);
      env_val  = env_diff >>> 1;
      raw      = 35'(sine_val) * 35'(env_val);
      if (!flags_i.in_click) begin
         prod_in = 32'sd0;
      end else if (raw > 35'sd1073741824) begin
         prod_in = 32'sd1073741824;
      end else if (raw < -35'sd1073741824) begin
         prod_in = -32'sd1073741824;
      end else begin
         prod_in = 32'(raw);
      end
   end

   // Times 32767, then divide by 2^30 rounding toward zero.
   always_comb begin
      scaled    = (48'(prod_ff) <<< 15) - 48'(prod_ff);
      biased    = scaled[47] ? scaled + 48'sd1073741823 : scaled;
      sample_in = biased[45:30];
   end

   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_ff  <= prod_in;
         flags_ff <= flags_i;
      end
      if (load_out) begin
         sample_ff     <= sample_in;
         beat_start_ff <= flags_ff.beat_start;
         track_last_ff <= flags_ff.track_last;
      end
   end

   assign sample_value = sample_ff;
   assign beat_start   = beat_start_ff;
   assign track_last   = track_last_ff;

endmodule
`default_nettype wire

### rtl/core/metronome_click_synth.sv
// Metronome click synthesiser, top level: one 16-bit sample per request.
// Each request passes through the stage registers in turn; the response is
// valid once it reaches the last. Throughput: one request per cycle while
// responses are taken; the beat counters and phase accumulators update in
// the accepting cycle, so nothing waits on a later stage.
// Reset (synchronous, active high) empties the pipeline, zeroes all counters
// and phases and loads the configuration registers with their defaults.
`default_nettype none
module metronome_click_synth #(
   parameter int BEATS_PER_BAR    = mcs_pkg::BEATS_PER_BAR_DEF,
   parameter int SINE_TABLE_DEPTH = mcs_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_restart,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_sample_value,
   output logic                    rsp_beat_start,
   output logic                    rsp_track_last,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [4:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int AW = $clog2(SINE_TABLE_DEPTH);

   // The pipeline has four stages:
   //   1. table addresses and per-sample flags, taken from the counters;
   //   2. registered reads of the sine table for tone and envelope cosine;
   //   3. envelope and product, clamped to the Q30 range;
   //   4. the scaled 16-bit sample, which is the response register.
   // Each stage loads when it is empty or when its contents move on, so
   // bubbles are squeezed out and a request is still taken while a finished
   // response waits for the consumer, as long as some stage is empty.

   mcs_pkg::cfg_type   cfg;
   logic [3:0]         vld_ff;
   logic [3:0]         vld_in;
   logic [3:0]         load;
   logic               accept;
   logic [AW-1:0]      tone_addr;
   logic [AW-1:0]      env_addr;
   mcs_pkg::flags_type flags_s1;
   mcs_pkg::flags_type flags_s2;
   logic signed [16:0] sine_val;
   logic signed [16:0] cosine_val;

   // The load chain runs from the output backwards.
   always_comb begin
      load[3]   = !vld_ff[3] || rsp_ready;
      load[2]   = !vld_ff[2] || load[3];
      load[1]   = !vld_ff[1] || load[2];
      load[0]   = !vld_ff[0] || load[1];
      req_ready = load[0];
      accept    = req_valid & load[0];

      vld_in    = vld_ff;
      if (load[0]) vld_in[0] = req_valid;
      if (load[1]) vld_in[1] = vld_ff[0];
      if (load[2]) vld_in[2] = vld_ff[1];
      if (load[3]) vld_in[3] = vld_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 4'd0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid  = vld_ff[3];
   assign csr_pready = 1'b1;

   mcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   // Counters advance only on an accepted request; the stage-one registers
   // load with the stage's own enable, so a stalled stage keeps its contents.
   mcs_sequencer #(
      .BEATS_PER_BAR    (BEATS_PER_BAR),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .AW               (AW)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .restart   (req_restart),
      .load      (load[0]),
      .tone_addr (tone_addr),
      .env_addr  (env_addr),
      .flags     (flags_s1)
   );

   mcs_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .AW               (AW)
   ) u_sine_rom (
      .clock      (clock),
      .load       (load[1]),
      .tone_addr  (tone_addr),
      .env_addr   (env_addr),
      .flags_i    (flags_s1),
      .sine_val   (sine_val),
      .cosine_val (cosine_val),
      .flags_o    (flags_s2)
   );

   mcs_mixer u_mixer (
      .clock        (clock),
      .load_prod    (load[2]),
      .load_out     (load[3]),
      .sine_val     (sine_val),
      .cosine_val   (cosine_val),
      .flags_i      (flags_s2),
      .sample_value (rsp_sample_value),
      .beat_start   (rsp_beat_start),
      .track_last   (rsp_track_last)
   );

endmodule
`default_nettype wire
